### hw/rtl/mck_pkg.sv
package mck_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned UNITS_W    = 3;
  localparam int unsigned MS_W       = 13;
  localparam int unsigned WPM_W      = 7;
  localparam int unsigned PAT_LEN_W  = 3;
  localparam int unsigned PAT_BITS_W = 7;
  localparam int unsigned PAT_COUNT  = 55;
  localparam int unsigned PAT_IDX_W  = 6;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned DIV_STEPS  = 3;

  localparam logic [WPM_W-1:0] WPM_RESET = 7'd20;
  localparam logic             REG_WPM   = 1'b0;

  localparam int unsigned MS_PER_UNIT = 1200;

  localparam logic [UNITS_W-1:0] UNITS_DIT   = 3'd1;
  localparam logic [UNITS_W-1:0] UNITS_DASH  = 3'd3;
  localparam logic [UNITS_W-1:0] UNITS_GAP   = 3'd3;
  localparam logic [UNITS_W-1:0] UNITS_SPACE = 3'd6;

  localparam logic [MS_W-1:0] DIVIDEND_1 = MS_W'(1 * MS_PER_UNIT);
  localparam logic [MS_W-1:0] DIVIDEND_3 = MS_W'(3 * MS_PER_UNIT);
  localparam logic [MS_W-1:0] DIVIDEND_6 = MS_W'(6 * MS_PER_UNIT);

  typedef struct packed {
    logic [PAT_LEN_W-1:0]  len;
    logic [PAT_BITS_W-1:0] bits;
  } pattern_t;

  // elements MSB first within len bits: 0 dit, 1 dash; len 0 is word space
  localparam pattern_t PATTERNS [PAT_COUNT] = '{
    '{3'd0, 7'h00},
    '{3'd2, 7'h01}, '{3'd4, 7'h08}, '{3'd4, 7'h0A}, '{3'd3, 7'h04}, '{3'd1, 7'h00},
    '{3'd4, 7'h02}, '{3'd3, 7'h06}, '{3'd4, 7'h00}, '{3'd2, 7'h00}, '{3'd4, 7'h07},
    '{3'd3, 7'h05}, '{3'd4, 7'h04}, '{3'd2, 7'h03}, '{3'd2, 7'h02}, '{3'd3, 7'h07},
    '{3'd4, 7'h06}, '{3'd4, 7'h0D}, '{3'd3, 7'h02}, '{3'd3, 7'h00}, '{3'd1, 7'h01},
    '{3'd3, 7'h01}, '{3'd4, 7'h01}, '{3'd3, 7'h03}, '{3'd4, 7'h09}, '{3'd4, 7'h0B},
    '{3'd4, 7'h0C},
    '{3'd5, 7'h1F}, '{3'd5, 7'h0F}, '{3'd5, 7'h07}, '{3'd5, 7'h03}, '{3'd5, 7'h01},
    '{3'd5, 7'h00}, '{3'd5, 7'h10}, '{3'd5, 7'h18}, '{3'd5, 7'h1C}, '{3'd5, 7'h1E},
    '{3'd6, 7'h15}, '{3'd6, 7'h33}, '{3'd6, 7'h0C},
    '{3'd6, 7'h1E}, '{3'd6, 7'h2B}, '{3'd5, 7'h12},
    '{3'd5, 7'h16}, '{3'd6, 7'h2D}, '{3'd5, 7'h08},
    '{3'd6, 7'h38}, '{3'd6, 7'h2A}, '{3'd5, 7'h11},
    '{3'd5, 7'h0A}, '{3'd6, 7'h21}, '{3'd6, 7'h0D},
    '{3'd6, 7'h12}, '{3'd7, 7'h09}, '{3'd6, 7'h1A}
  };

  function automatic logic [PAT_IDX_W-1:0] pattern_index(input logic [CHAR_W-1:0] c);
    logic [PAT_IDX_W-1:0] idx;
    idx = '0;
    if (c inside {[8'd48:8'd57]}) begin
      idx = PAT_IDX_W'(c - 8'd21);
    end else if (c inside {[8'd65:8'd90]}) begin
      idx = PAT_IDX_W'(c - 8'd64);
    end else if (c inside {[8'd97:8'd122]}) begin
      idx = PAT_IDX_W'(c - 8'd96);
    end else begin
      case (c)
        8'h2E:   idx = 6'd37;  // .
        8'h2C:   idx = 6'd38;  // ,
        8'h3F:   idx = 6'd39;  // ?
        8'h27:   idx = 6'd40;  // '
        8'h21:   idx = 6'd41;  // !
        8'h2F:   idx = 6'd42;  // /
        8'h28:   idx = 6'd43;  // (
        8'h29:   idx = 6'd44;  // )
        8'h26:   idx = 6'd45;  // &
        8'h3A:   idx = 6'd46;  // :
        8'h3B:   idx = 6'd47;  // ;
        8'h3D:   idx = 6'd48;  // =
        8'h2B:   idx = 6'd49;  // +
        8'h2D:   idx = 6'd50;  // -
        8'h5F:   idx = 6'd51;  // _
        8'h22:   idx = 6'd52;  // "
        8'h24:   idx = 6'd53;  // $
        8'h40:   idx = 6'd54;  // @
        default: idx = 6'd0;
      endcase
    end
    return idx;
  endfunction

  function automatic pattern_t pattern_lookup(input logic [CHAR_W-1:0] c);
    return PATTERNS[pattern_index(c)];
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SPACE,
    ST_ON,
    ST_OFF,
    ST_GAP
  } state_t;

  typedef enum logic [1:0] {
    SEG_ELEMENT,
    SEG_ELEM_GAP,
    SEG_SPACE,
    SEG_CHAR_GAP
  } seg_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic emit;
    seg_t seg;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_finished;
    logic is_space;
    logic elems_left;
    logic out_free;
  } dp_status_t;

endpackage

### hw/rtl/mck_if.sv
interface mck_char_if;
  logic                       valid;
  logic                       ready;
  logic [mck_pkg::CHAR_W-1:0] character;

  modport source (output valid, output character, input ready);
  modport sink (input valid, input character, output ready);
endinterface

interface mck_seg_if;
  logic                        valid;
  logic                        ready;
  logic                        key_on;
  logic [mck_pkg::UNITS_W-1:0] units;
  logic [mck_pkg::MS_W-1:0]    duration_ms;
  logic                        last;

  modport source (output valid, output key_on, output units, output duration_ms,
                  output last, input ready);
  modport sink (input valid, input key_on, input units, input duration_ms,
                input last, output ready);
endinterface

### hw/rtl/mck_regs.sv
module mck_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mck_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [mck_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [mck_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [mck_pkg::WPM_W-1:0]        wpm
);

  logic hit;

  assign hit    = (paddr[2] == mck_pkg::REG_WPM);
  assign pready = 1'b1;
  assign prdata = hit ? mck_pkg::APB_DATA_W'(wpm) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wpm <= mck_pkg::WPM_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      wpm <= pwdata[mck_pkg::WPM_W-1:0];
    end
  end

endmodule

### hw/rtl/mck_div.sv
module mck_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mck_pkg::MS_W-1:0]      dividend,
  input  logic [mck_pkg::WPM_W-1:0]     divisor,
  output logic                          busy,
  output logic                          done,
  output logic [mck_pkg::MS_W-1:0]      quotient
);

  localparam int unsigned CNT_W = $clog2(mck_pkg::MS_W);

  logic [CNT_W-1:0]            cnt;
  logic [mck_pkg::MS_W-1:0]    dvd;
  logic [mck_pkg::MS_W-1:0]    quo;
  logic [mck_pkg::WPM_W-1:0]   rem;
  logic [mck_pkg::WPM_W-1:0]   dsr;
  logic [mck_pkg::WPM_W:0]     trial;
  logic [mck_pkg::WPM_W:0]     diff;
  logic                        ge;
  logic [mck_pkg::WPM_W-1:0]   rem_next;

  // restoring division, one quotient bit per cycle
  assign trial    = {rem, dvd[mck_pkg::MS_W-1]};
  assign diff     = trial - {1'b0, dsr};
  assign ge       = (trial >= {1'b0, dsr});
  assign rem_next = ge ? diff[mck_pkg::WPM_W-1:0] : trial[mck_pkg::WPM_W-1:0];

  assign done     = busy && (cnt == '0);
  assign quotient = {quo[mck_pkg::MS_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= CNT_W'(mck_pkg::MS_W - 1);
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      dvd <= {dvd[mck_pkg::MS_W-2:0], 1'b0};
      rem <= rem_next;
      quo <= quotient;
    end
  end

endmodule

### hw/rtl/mck_datapath.sv
module mck_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mck_pkg::CHAR_W-1:0]    character,
  input  logic [mck_pkg::WPM_W-1:0]     wpm,
  input  mck_pkg::ctrl_cmd_t            cmd,
  output mck_pkg::dp_status_t           status,
  mck_seg_if.source                     seg_out
);

  mck_pkg::pattern_t                 pat;
  logic [mck_pkg::PAT_LEN_W-1:0]     len_left;
  logic [mck_pkg::PAT_BITS_W-1:0]    bits;
  logic                              is_space;
  logic [1:0]                        div_sel;
  logic [mck_pkg::MS_W-1:0]          quo [mck_pkg::DIV_STEPS];
  logic [mck_pkg::MS_W-1:0]          dividend;
  logic [mck_pkg::WPM_W-1:0]         divisor;
  logic                              div_busy;
  logic                              div_done;
  logic [mck_pkg::MS_W-1:0]          div_q;
  logic                              out_valid;

  assign pat     = mck_pkg::pattern_lookup(character);
  assign divisor = (wpm == '0) ? mck_pkg::WPM_W'(1) : wpm;

  always_comb begin
    case (div_sel)
      2'd0:    dividend = mck_pkg::DIVIDEND_1;
      2'd1:    dividend = mck_pkg::DIVIDEND_3;
      default: dividend = mck_pkg::DIVIDEND_6;
    endcase
  end

  mck_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      div_sel <= 2'(mck_pkg::DIV_STEPS);
    end else if (cmd.load) begin
      div_sel <= '0;
    end else if (div_done) begin
      div_sel <= div_sel + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      quo[div_sel] <= div_q;
    end
  end

  // current element sits in the top bit of bits
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      len_left <= pat.len;
      bits     <= pat.bits << (3'd7 - pat.len);
      is_space <= (pat.len == '0);
    end else if (cmd.emit && cmd.seg == mck_pkg::SEG_ELEMENT) begin
      len_left <= len_left - 1'b1;
      bits     <= {bits[mck_pkg::PAT_BITS_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (seg_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.seg)
        mck_pkg::SEG_ELEMENT: begin
          seg_out.key_on      <= 1'b1;
          seg_out.units       <= bits[mck_pkg::PAT_BITS_W-1] ? mck_pkg::UNITS_DASH
                                                             : mck_pkg::UNITS_DIT;
          seg_out.duration_ms <= bits[mck_pkg::PAT_BITS_W-1] ? quo[1] : quo[0];
          seg_out.last        <= 1'b0;
        end
        mck_pkg::SEG_ELEM_GAP: begin
          seg_out.key_on      <= 1'b0;
          seg_out.units       <= mck_pkg::UNITS_DIT;
          seg_out.duration_ms <= quo[0];
          seg_out.last        <= 1'b0;
        end
        mck_pkg::SEG_SPACE: begin
          seg_out.key_on      <= 1'b0;
          seg_out.units       <= mck_pkg::UNITS_SPACE;
          seg_out.duration_ms <= quo[2];
          seg_out.last        <= 1'b0;
        end
        default: begin
          seg_out.key_on      <= 1'b0;
          seg_out.units       <= mck_pkg::UNITS_GAP;
          seg_out.duration_ms <= quo[1];
          seg_out.last        <= 1'b1;
        end
      endcase
    end
  end

  assign seg_out.valid = out_valid;

  assign status.div_busy     = div_busy;
  assign status.div_finished = (div_sel == 2'(mck_pkg::DIV_STEPS));
  assign status.is_space     = is_space;
  assign status.elems_left   = (len_left != '0);
  assign status.out_free     = !out_valid || seg_out.ready;

endmodule

### hw/rtl/mck_ctrl.sv
module mck_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mck_pkg::dp_status_t  status,
  output mck_pkg::ctrl_cmd_t   cmd,
  output mck_pkg::state_t      state
);

  mck_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mck_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.seg    = mck_pkg::SEG_ELEMENT;
    case (state)
      mck_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = mck_pkg::ST_DIV;
        end
      end
      mck_pkg::ST_DIV: begin
        if (!status.div_busy) begin
          if (status.div_finished) begin
            state_next = status.is_space ? mck_pkg::ST_SPACE : mck_pkg::ST_ON;
          end else begin
            cmd.div_start = 1'b1;
          end
        end
      end
      mck_pkg::ST_SPACE: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.seg    = mck_pkg::SEG_SPACE;
          state_next = mck_pkg::ST_OFF;
        end
      end
      mck_pkg::ST_ON: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.seg    = mck_pkg::SEG_ELEMENT;
          state_next = mck_pkg::ST_OFF;
        end
      end
      mck_pkg::ST_OFF: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.seg    = mck_pkg::SEG_ELEM_GAP;
          state_next = status.elems_left ? mck_pkg::ST_ON : mck_pkg::ST_GAP;
        end
      end
      mck_pkg::ST_GAP: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.seg    = mck_pkg::SEG_CHAR_GAP;
          state_next = mck_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mck_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/morse_character_keyer_unit.sv
// Morse keyer: takes one ASCII character on char_in and sends it on seg_out as
// timed key segments, one per item: an element (dit 1 unit, dash 3 units,
// key on) and a 1-unit key-off after each, or for an unmapped character a
// 6-unit word space and a 1-unit key-off, and always a closing 3-unit key-off
// marked last. duration_ms is units*1200/wpm truncated, wpm 0 counts as 1.
// Speed is set through the APB register at address 0 (reset 20); the user is to
// write it only while idle, which the block itself does not enforce. A character
// is accepted in ST_IDLE, then three serial divisions (1, 3 and 6 units) run one
// after another on one shared divider in ST_DIV, then one segment (3 to 15 in
// all) goes out per cycle while the consumer keeps up.
// One character is in flight at a time; the output register lets the last
// segment wait while the next character is accepted.
module morse_character_keyer_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mck_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [mck_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [mck_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  mck_char_if.sink                         char_in,
  mck_seg_if.source                        seg_out
);

  logic [mck_pkg::WPM_W-1:0] wpm;
  logic                      in_ready;
  mck_pkg::ctrl_cmd_t        cmd;
  mck_pkg::dp_status_t       status;
  mck_pkg::state_t           state;

  assign char_in.ready = in_ready;

  mck_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .wpm     (wpm)
  );

  mck_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (char_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd),
    .state    (state)
  );

  mck_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .character (char_in.character),
    .wpm       (wpm),
    .cmd       (cmd),
    .status    (status),
    .seg_out   (seg_out)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (char_in.valid && char_in.ready) |=> !char_in.ready)
    else $error("keyer ready right after accepting an item");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> (!status.div_busy && state == mck_pkg::ST_DIV))
    else $error("divider restarted while busy");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("segment overwrote a pending item");

  a_dur_nonzero: assert property (@(posedge clk) disable iff (rst)
    seg_out.valid |-> (seg_out.duration_ms != '0))
    else $error("zero segment duration");

endmodule

### tb/morse_character_keyer_unit_test.sv
`timescale 1ns / 1ps

module morse_character_keyer_unit_test;

  typedef struct packed {
    logic                        key_on;
    logic [mck_pkg::UNITS_W-1:0] units;
    logic [mck_pkg::MS_W-1:0]    duration_ms;
    logic                        last;
  } key_segment_t;

  typedef key_segment_t [0:2] segment_triple_t;

  typedef enum logic {
    ROW_CHAR,
    ROW_WPM
  } row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    logic [7:0]      value;
    logic            typed;
    segment_triple_t segs;
  } stim_row_t;

  localparam logic [mck_pkg::APB_ADDR_W-1:0] ADDR_WPM =
    mck_pkg::APB_ADDR_W'(4 * mck_pkg::REG_WPM);
  localparam logic [mck_pkg::WPM_W-1:0] WPM_AFTER_RESET = 7'd20;
  localparam int unsigned MS_PER_UNIT_WPM = 1200;
  localparam int PHASES          = 4;
  localparam int PHASE_ITEMS     = 34;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT  = 5000;

  localparam segment_triple_t SEGS_SPACE_20 =
    {{1'b0, 3'd6, 13'd360, 1'b0}, {1'b0, 3'd1, 13'd60, 1'b0}, {1'b0, 3'd3, 13'd180, 1'b1}};
  localparam segment_triple_t SEGS_E_20 =
    {{1'b1, 3'd1, 13'd60, 1'b0}, {1'b0, 3'd1, 13'd60, 1'b0}, {1'b0, 3'd3, 13'd180, 1'b1}};
  localparam segment_triple_t SEGS_T_20 =
    {{1'b1, 3'd3, 13'd180, 1'b0}, {1'b0, 3'd1, 13'd60, 1'b0}, {1'b0, 3'd3, 13'd180, 1'b1}};
  localparam segment_triple_t SEGS_SPACE_1 =
    {{1'b0, 3'd6, 13'd7200, 1'b0}, {1'b0, 3'd1, 13'd1200, 1'b0},
     {1'b0, 3'd3, 13'd3600, 1'b1}};
  localparam segment_triple_t SEGS_E_1 =
    {{1'b1, 3'd1, 13'd1200, 1'b0}, {1'b0, 3'd1, 13'd1200, 1'b0},
     {1'b0, 3'd3, 13'd3600, 1'b1}};
  localparam segment_triple_t SEGS_T_1 =
    {{1'b1, 3'd3, 13'd3600, 1'b0}, {1'b0, 3'd1, 13'd1200, 1'b0},
     {1'b0, 3'd3, 13'd3600, 1'b1}};
  localparam segment_triple_t SEGS_E_100 =
    {{1'b1, 3'd1, 13'd12, 1'b0}, {1'b0, 3'd1, 13'd12, 1'b0}, {1'b0, 3'd3, 13'd36, 1'b1}};
  localparam segment_triple_t SEGS_SPACE_127 =
    {{1'b0, 3'd6, 13'd56, 1'b0}, {1'b0, 3'd1, 13'd9, 1'b0}, {1'b0, 3'd3, 13'd28, 1'b1}};

  localparam int N_DIRECTED = 28;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_CHAR, "E",   1'b1, SEGS_E_20},
    '{ROW_CHAR, "T",   1'b1, SEGS_T_20},
    '{ROW_CHAR, 8'h00, 1'b1, SEGS_SPACE_20},
    '{ROW_CHAR, 8'hFF, 1'b1, SEGS_SPACE_20},
    '{ROW_CHAR, 8'h80, 1'b1, SEGS_SPACE_20},
    '{ROW_CHAR, 8'h7F, 1'b1, SEGS_SPACE_20},
    '{ROW_CHAR, " ",   1'b1, SEGS_SPACE_20},
    '{ROW_CHAR, "$",   1'b0, '0},
    '{ROW_CHAR, "@",   1'b0, '0},
    '{ROW_CHAR, "a",   1'b0, '0},
    '{ROW_CHAR, "Z",   1'b0, '0},
    '{ROW_CHAR, "0",   1'b0, '0},
    '{ROW_CHAR, "9",   1'b0, '0},
    '{ROW_CHAR, ".",   1'b0, '0},
    '{ROW_CHAR, "_",   1'b0, '0},
    '{ROW_CHAR, "\"",  1'b0, '0},
    '{ROW_CHAR, "q",   1'b0, '0},
    '{ROW_WPM,  8'd1,  1'b0, '0},
    '{ROW_CHAR, " ",   1'b1, SEGS_SPACE_1},
    '{ROW_CHAR, "e",   1'b1, SEGS_E_1},
    '{ROW_WPM,  8'd0,  1'b0, '0},
    '{ROW_CHAR, "T",   1'b1, SEGS_T_1},
    '{ROW_WPM,  8'd100, 1'b0, '0},
    '{ROW_CHAR, "E",   1'b1, SEGS_E_100},
    '{ROW_WPM,  8'd127, 1'b0, '0},
    '{ROW_CHAR, "?",   1'b0, '0},
    '{ROW_CHAR, 8'h01, 1'b1, SEGS_SPACE_127},
    '{ROW_CHAR, "S",   1'b0, '0}
  };

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [mck_pkg::APB_ADDR_W-1:0]  paddr;
  logic [mck_pkg::APB_DATA_W-1:0]  pwdata;
  logic [mck_pkg::APB_DATA_W-1:0]  prdata;
  logic                            pready;

  mck_char_if char_in ();
  mck_seg_if  seg_out ();

  key_segment_t               pending_segments [$];
  logic [mck_pkg::WPM_W-1:0]  speed_wpm;
  int                         mismatch_count = 0;
  int                         send_idle_pct = 0;
  int                         recv_stall_pct = 0;
  int                         hold_left = 0;
  logic                       hold_req = 1'b0;
  int                         idle_cycles = 0;

  morse_character_keyer_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .char_in (char_in),
    .seg_out (seg_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic string morse_of(input logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    case (u)
      "A": return ".-";     "B": return "-...";   "C": return "-.-.";   "D": return "-..";
      "E": return ".";      "F": return "..-.";   "G": return "--.";    "H": return "....";
      "I": return "..";     "J": return ".---";   "K": return "-.-";    "L": return ".-..";
      "M": return "--";     "N": return "-.";     "O": return "---";    "P": return ".--.";
      "Q": return "--.-";   "R": return ".-.";    "S": return "...";    "T": return "-";
      "U": return "..-";    "V": return "...-";   "W": return ".--";    "X": return "-..-";
      "Y": return "-.--";   "Z": return "--..";
      "0": return "-----";  "1": return ".----";  "2": return "..---";  "3": return "...--";
      "4": return "....-";  "5": return ".....";  "6": return "-....";  "7": return "--...";
      "8": return "---..";  "9": return "----.";
      ".": return ".-.-.-"; ",": return "--..--"; "?": return "..--.."; "'": return ".----.";
      "!": return "-.-.--"; "/": return "-..-.";  "(": return "-.--.";  ")": return "-.--.-";
      "&": return ".-...";  ":": return "---..."; ";": return "-.-.-."; "=": return "-...-";
      "+": return ".-.-.";  "-": return "-....-"; "_": return "..--.-"; "\"": return ".-..-.";
      "$": return "...-..-"; "@": return ".--.-.";
      default: return "";
    endcase
  endfunction

  function automatic key_segment_t timed_segment(input logic on, input int unsigned units,
                                                 input logic last);
    int unsigned  rate;
    key_segment_t s;
    rate = (speed_wpm == 0) ? 1 : speed_wpm;
    s.key_on      = on;
    s.units       = mck_pkg::UNITS_W'(units);
    s.duration_ms = mck_pkg::MS_W'((units * MS_PER_UNIT_WPM) / rate);
    s.last        = last;
    return s;
  endfunction

  function automatic void predict_segments(input logic [7:0] c);
    string code;
    code = morse_of(c);
    if (code.len() == 0) begin
      pending_segments.push_back(timed_segment(1'b1 ^ 1'b1, 6, 1'b0));
      pending_segments.push_back(timed_segment(1'b0, 1, 1'b0));
    end else begin
      for (int i = 0; i < code.len(); i++) begin
        pending_segments.push_back(timed_segment(1'b1, (code[i] == "-") ? 3 : 1, 1'b0));
        pending_segments.push_back(timed_segment(1'b0, 1, 1'b0));
      end
    end
    pending_segments.push_back(timed_segment(1'b0, 3, 1'b1));
  endfunction

  task automatic report_error(input string msg);
    $display("tb: mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      char_in.valid <= 1'b0;
      @(posedge clk);
    end
    char_in.valid     <= 1'b1;
    char_in.character <= c;
    do @(posedge clk); while (!char_in.ready);
  endtask

  task automatic drain_segments();
    char_in.valid <= 1'b0;
    do @(posedge clk); while (pending_segments.size() != 0);
  endtask

  task automatic write_wpm(input logic [mck_pkg::WPM_W-1:0] v);
    drain_segments();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WPM;
    pwdata  <= mck_pkg::APB_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    speed_wpm = v;
    // read back right away, psel stays high
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== mck_pkg::APB_DATA_W'(v)) begin
      report_error($sformatf("wpm readback got %0d want %0d", prdata, v));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      seg_out.ready <= 1'b0;
    end else begin
      seg_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : seg_check
    key_segment_t want;
    if (!rst) begin
      if (seg_out.valid && seg_out.ready) begin
        if (pending_segments.size() == 0) begin
          report_error($sformatf("unexpected segment key_on %0d units %0d ms %0d last %0d",
                                 seg_out.key_on, seg_out.units, seg_out.duration_ms,
                                 seg_out.last));
        end else begin
          want = pending_segments.pop_front();
          if (seg_out.key_on !== want.key_on) begin
            report_error($sformatf("key_on got %0d want %0d", seg_out.key_on, want.key_on));
          end
          if (seg_out.units !== want.units) begin
            report_error($sformatf("units got %0d want %0d", seg_out.units, want.units));
          end
          if (seg_out.duration_ms !== want.duration_ms) begin
            report_error($sformatf("duration_ms got %0d want %0d",
                                   seg_out.duration_ms, want.duration_ms));
          end
          if (seg_out.last !== want.last) begin
            report_error($sformatf("last got %0d want %0d", seg_out.last, want.last));
          end
        end
      end
      if ((seg_out.valid && seg_out.ready) || (char_in.valid && char_in.ready) ||
          (psel && penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    stim_row_t  row;
    logic [7:0] c;
    string      alphabet;
    alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789.,?'!/()&:;=+-_\"$@ ";
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    char_in.valid     = 1'b0;
    char_in.character = '0;
    seg_out.ready     = 1'b0;
    speed_wpm         = WPM_AFTER_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_WPM) begin
        write_wpm(row.value[mck_pkg::WPM_W-1:0]);
      end else begin
        send_char(row.value);
        if (row.typed) begin
          for (int j = 0; j < 3; j++) pending_segments.push_back(row.segs[j]);
        end else begin
          predict_segments(row.value);
        end
      end
    end

    // phases: no idling (but one receiver hold-off), sender idle, receiver stalls, both
    for (int p = 0; p < PHASES; p++) begin
      write_wpm(mck_pkg::WPM_W'($urandom_range(127)));
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 63;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 63;
        end
        default: begin
          send_idle_pct  = 17;
          recv_stall_pct = 17;
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 0 && k == 10) hold_req = 1'b1;
        if (p == 1 && k == 20) drain_segments();
        if ($urandom_range(3) == 0) begin
          c = 8'($urandom_range(255));
        end else begin
          c = alphabet[$urandom_range(alphabet.len() - 1)];
        end
        send_char(c);
        predict_segments(c);
      end
    end

    drain_segments();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/mck_pkg.sv
hw/rtl/mck_if.sv
hw/rtl/mck_regs.sv
hw/rtl/mck_div.sv
hw/rtl/mck_datapath.sv
hw/rtl/mck_ctrl.sv
hw/rtl/morse_character_keyer_unit.sv
tb/morse_character_keyer_unit_test.sv
